// File: sv/cdqs_pkg.sv
// Shared constants, types and helper functions of the circular deque with search.
`timescale 1ns / 1ps
package cdqs_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int OUT_CNT_W  = 5;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_SEARCH     = 3'd4,
      ACT_LENGTH     = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  popped_value;
      logic [OUT_CNT_W-1:0]       entry_count;
   } rsp_type;

   typedef struct packed {
      logic     we;
      idx_type  waddr;
      word_type wdata;
      logic     re;
      idx_type  raddr;
   } ram_req_type;

   function automatic word_type to_word(input logic [VALUE_W-1:0] v);
      return DATA_WIDTH'(v);
   endfunction

   function automatic logic [VALUE_W-1:0] from_word(input word_type w);
      return VALUE_W'(w);
   endfunction

   function automatic idx_type slot_add(input idx_type base, input cnt_type off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// File: sv/cdqs_req_if.sv
// Request channel interface: action and value with valid/ready.
`timescale 1ns / 1ps
interface cdqs_req_if
   import cdqs_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);
endinterface

// File: sv/cdqs_rsp_if.sv
// Response channel interface: status, popped value and entry count with valid/ready.
`timescale 1ns / 1ps
interface cdqs_rsp_if
   import cdqs_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] popped_value;
   logic [OUT_CNT_W-1:0]      entry_count;

   modport source (output valid, status, popped_value, entry_count, input ready);
   modport sink   (input valid, status, popped_value, entry_count, output ready);
endinterface

// File: sv/circular_deque_with_search.sv
// Top level of the circular deque with search: sequencer, ring RAM and response register.
// Push, length and rejected actions go from idle straight to the reply state; pops pass through
// a pop state for the RAM read data; a search compares entries in order, one RAM read per cycle.
// One item is worked at a time; the next item is taken while a result waits in the
// response register. Synchronous reset empties the deque; RAM contents stay undefined.
`timescale 1ns / 1ps
module circular_deque_with_search
   import cdqs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   cdqs_req_if.sink       req_chan,
   cdqs_rsp_if.source     rsp_chan
);
   logic        out_free;
   logic        reply_valid;
   rsp_type     reply;
   ram_req_type ram_req;
   word_type    ram_rdata;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   cdqs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_action  (req_chan.action),
      .req_value   (req_chan.value),
      .out_free    (out_free),
      .reply_valid (reply_valid),
      .reply       (reply),
      .ram_req     (ram_req),
      .ram_rdata   (ram_rdata)
   );

   cdqs_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (reply_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = reply;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.popped_value = rsp_data_ff.popped_value;
   assign rsp_chan.entry_count  = rsp_data_ff.entry_count;
endmodule

// File: sv/cdqs_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module cdqs_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/cdqs_ctrl.sv
// Deque sequencer: ring pointers, push/pop addressing and the search scan.
`timescale 1ns / 1ps
module cdqs_ctrl
   import cdqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic                  out_free,
   output logic                  reply_valid,
   output rsp_type               reply,
   output ram_req_type           ram_req,
   input  word_type              ram_rdata
);
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_POP   = 4'b0010,
      S_SCAN  = 4'b0100,
      S_REPLY = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   idx_type              front_ff, front_in;
   cnt_type              count_ff, count_in;
   cnt_type              scan_ff, scan_in;
   word_type             word_ff, word_in;
   status_type           status_ff, status_in;
   logic [VALUE_W-1:0]   popped_ff, popped_in;

   logic    full;
   logic    empty;
   idx_type front_prev;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign front_prev = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      word_in     = word_ff;
      status_in   = status_ff;
      popped_in   = popped_ff;
      reply_valid = 1'b0;
      ram_req     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               word_in   = to_word(req_value);
               status_in = ST_DONE;
               popped_in = '0;
               state_in  = S_REPLY;
               unique case (req_action)
                  ACT_PUSH_BACK: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = slot_add(front_ff, count_ff);
                        ram_req.wdata = to_word(req_value);
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  ACT_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = front_prev;
                        ram_req.wdata = to_word(req_value);
                        front_in      = front_prev;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = front_ff;
                        front_in      = slot_add(front_ff, CNT_W'(1));
                        count_in      = count_ff - 1'b1;
                        state_in      = S_POP;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = slot_add(front_ff, count_ff - 1'b1);
                        count_in      = count_ff - 1'b1;
                        state_in      = S_POP;
                     end
                  end
                  ACT_SEARCH: begin
                     if (empty) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = front_ff;
                        scan_in       = CNT_W'(1);
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            popped_in = from_word(ram_rdata);
            state_in  = S_REPLY;
         end
         S_SCAN: begin
            priority if (ram_rdata == word_ff) begin
               status_in = ST_FOUND;
               state_in  = S_REPLY;
            end else if (scan_ff == count_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_REPLY;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = slot_add(front_ff, scan_ff);
               scan_in       = scan_ff + 1'b1;
            end
         end
         S_REPLY: begin
            reply_valid = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      word_ff   <= word_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign reply.status       = status_ff;
   assign reply.popped_value = popped_ff;
   assign reply.entry_count  = OUT_CNT_W'(count_ff);
endmodule
